// ===== rtl/adler32_checksum_update_macros.svh =====
// Assertion macros for the adler32 RTL.
`ifndef ADLER32_CHECKSUM_UPDATE_MACROS_SVH
`define ADLER32_CHECKSUM_UPDATE_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ADLER32_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ADLER32_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/adler32_pkg.sv =====
// Package: Adler-32 constants, widths and transaction types.
`default_nettype none

package adler32_pkg;

    localparam int LANES    = 8;
    localparam int BYTE_W   = 8;
    localparam int DATA_W   = 64;
    localparam int CNT_W    = 4;
    localparam int SUM_W    = 16;
    localparam int BYTE_MAX = 255;

    localparam logic [SUM_W:0]   ADLER_MOD = 17'd65521;
    // 2^16 mod 65521
    localparam int               FOLD      = 15;
    localparam logic [CNT_W-1:0] LANES_CNT = CNT_W'(LANES);

    // plain byte sum and weighted byte sum over one beat
    localparam int S_W  = $clog2(BYTE_MAX * LANES + 1);
    localparam int LW_W = $clog2(BYTE_MAX * LANES + 1);
    localparam int W_W  = $clog2(BYTE_MAX * LANES * (LANES + 1) / 2 + 1);
    // unreduced weighted-sum update: B + n*A + W
    localparam int T_W  = $clog2(65520 * (LANES + 1) + BYTE_MAX * LANES * (LANES + 1) / 2 + 1);

    typedef struct packed {
        logic [DATA_W-1:0] data_bytes;
        logic [CNT_W-1:0]  byte_count;
        logic              clear;
    } t_in_item;

    typedef struct packed {
        logic [SUM_W-1:0]   sum_a;
        logic [SUM_W-1:0]   sum_b;
        logic [2*SUM_W-1:0] checksum;
    } t_out_item;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_m;
        logic [LW_W-1:0]   wprod;
    } t_lane_out;

    typedef struct packed {
        logic             clear;
        logic [CNT_W-1:0] n;
        logic [S_W-1:0]   s;
        logic [W_W-1:0]   w;
    } t_stage1;

endpackage

`default_nettype wire

// ===== rtl/adler32_checksum_update.sv =====
// Top level: Adler-32 running checksum, eight byte lanes per transaction.
//
// Usage
//   Input channel  (i_in_valid / o_in_ready / i_in_item): one transaction
//   carries up to eight bytes, first byte in bits 7:0, with byte_count valid
//   bytes taken from the low end (counts above eight act as eight). clear
//   restarts the checksum at A = 1, B = 0 and ignores the data.
//   Output channel (o_out_valid / i_out_ready / o_out_item): exactly one
//   transaction per input transaction, in order, carrying the reduced sums
//   and the packed checksum {B, A}.
//   Path: an accepted input is registered in stage 1; the A/B update then
//   writes the sum registers, which present the result (a held output stalls it).
//   Throughput: one transaction per cycle while the receiver keeps up, set by
//   the A/B update loop in adler32_fold (multiply by count, add, fold, one subtract).
//   Reset: synchronous, active low; sums return to A = 1, B = 0, both
//   pipeline stages empty.
//   Stall: the output sums are the state registers themselves and freeze
//   while the receiver holds off; the lane stage still takes one more
//   transaction, then o_in_ready drops until the result is taken.
`default_nettype none

module adler32_checksum_update (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  adler32_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output adler32_pkg::t_out_item o_out_item
);
    import adler32_pkg::*;

    t_lane_out        lanes [LANES];
    logic [CNT_W-1:0] count_sat;
    t_stage1          s1_next;
    t_stage1          r_s1;
    logic             r_s1_vld, n_s1_vld;
    logic             r_out_vld, n_out_vld;
    logic             upd_en;
    logic             in_take;
    logic [SUM_W-1:0] sum_a, sum_b;

    // clamp over-long counts to the lane count
    assign count_sat = (i_in_item.byte_count > LANES_CNT) ? LANES_CNT
                                                          : i_in_item.byte_count;

    // byte lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        adler32_lane u_lane (
            .i_byte     (i_in_item.data_bytes[g*BYTE_W +: BYTE_W]),
            .i_lane_idx (CNT_W'(g)),
            .i_count    (count_sat),
            .o_lane     (lanes[g])
        );
    end

    // merge: plain and weighted byte sums across lanes
    always_comb begin
        s1_next.clear = i_in_item.clear;
        s1_next.n     = i_in_item.clear ? '0 : count_sat;
        s1_next.s     = '0;
        s1_next.w     = '0;
        for (int k = 0; k < LANES; k++) begin
            s1_next.s = s1_next.s + S_W'(lanes[k].byte_m);
            s1_next.w = s1_next.w + W_W'(lanes[k].wprod);
        end
    end

    // handshake: update sums when stage 1 holds work and the output slot is free
    assign upd_en     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || upd_en;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_s1_vld  = in_take ? 1'b1 : (upd_en ? 1'b0 : r_s1_vld);
        n_out_vld = upd_en ? 1'b1 : (i_out_ready ? 1'b0 : r_out_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // stage 1 payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1 <= s1_next;
        end
    end

    // A/B state; doubles as the output register
    adler32_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (upd_en),
        .i_s1    (r_s1),
        .o_sum_a (sum_a),
        .o_sum_b (sum_b)
    );

    assign o_out_valid         = r_out_vld;
    assign o_out_item.sum_a    = sum_a;
    assign o_out_item.sum_b    = sum_b;
    assign o_out_item.checksum = {sum_b, sum_a};

endmodule

`default_nettype wire

// ===== rtl/adler32_lane.sv =====
// One byte lane: masks the byte and weights it by its distance from the beat end.
`default_nettype none

module adler32_lane (
    input  logic [adler32_pkg::BYTE_W-1:0] i_byte,
    input  logic [adler32_pkg::CNT_W-1:0]  i_lane_idx,
    input  logic [adler32_pkg::CNT_W-1:0]  i_count,
    output adler32_pkg::t_lane_out         o_lane
);
    import adler32_pkg::*;

    logic             lane_on;
    logic [CNT_W-1:0] weight;

    always_comb begin
        lane_on       = (i_lane_idx < i_count);
        weight        = lane_on ? (i_count - i_lane_idx) : '0;
        o_lane.byte_m = lane_on ? i_byte : '0;
        o_lane.wprod  = LW_W'(LW_W'(i_byte) * LW_W'(weight));
    end

endmodule

`default_nettype wire

// ===== rtl/adler32_fold.sv =====
// Running sums A and B with the modulo-65521 update.
`default_nettype none

module adler32_fold (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  adler32_pkg::t_stage1          i_s1,
    output logic [adler32_pkg::SUM_W-1:0] o_sum_a,
    output logic [adler32_pkg::SUM_W-1:0] o_sum_b
);
    import adler32_pkg::*;
    `include "adler32_checksum_update_macros.svh"

    localparam int P_W = SUM_W + CNT_W;

    logic [SUM_W-1:0] r_sum_a, r_sum_b;
    logic [SUM_W-1:0] n_sum_a, n_sum_b;
    logic [SUM_W:0]   a_raw, a_red, b_fold, b_red;
    logic [P_W-1:0]   na_prod;
    logic [T_W-1:0]   b_raw;

    always_comb begin
        a_raw   = {1'b0, r_sum_a} + (SUM_W+1)'(i_s1.s);
        a_red   = (a_raw >= ADLER_MOD) ? (a_raw - ADLER_MOD) : a_raw;
        // B gains n copies of the old A plus the lane-weighted bytes
        na_prod = P_W'(i_s1.n) * P_W'(r_sum_a);
        b_raw   = T_W'(r_sum_b) + T_W'(na_prod) + T_W'(i_s1.w);
        // 2^16 == 15 (mod 65521): fold the top bits back in, then one subtract
        b_fold  = (SUM_W+1)'(b_raw[T_W-1:SUM_W]) * (SUM_W+1)'(FOLD)
                + {1'b0, b_raw[SUM_W-1:0]};
        b_red   = (b_fold >= ADLER_MOD) ? (b_fold - ADLER_MOD) : b_fold;
        if (i_s1.clear) begin
            n_sum_a = SUM_W'(1);
            n_sum_b = '0;
        end else begin
            n_sum_a = a_red[SUM_W-1:0];
            n_sum_b = b_red[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= SUM_W'(1);
            r_sum_b <= '0;
        end else if (i_en) begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

    assign o_sum_a = r_sum_a;
    assign o_sum_b = r_sum_b;

    `ADLER32_ASSERT(a_reduced, i_clk, i_rst_n, ({1'b0, r_sum_a} < ADLER_MOD), "sum A out of range")
    `ADLER32_ASSERT(b_reduced, i_clk, i_rst_n, ({1'b0, r_sum_b} < ADLER_MOD), "sum B out of range")
    `ADLER32_ASSERT(clear_restarts, i_clk, i_rst_n, i_en && i_s1.clear |=> (r_sum_a == SUM_W'(1)) && (r_sum_b == '0), "clear did not restart sums")
    `ADLER32_ASSERT(hold_when_idle, i_clk, i_rst_n, !i_en |=> $stable(r_sum_a) && $stable(r_sum_b), "sums moved without an update")

endmodule

`default_nettype wire
